### rtl/kdeq_pkg.sv
// shared types and codes for the keyed record deque
package kdeq_pkg;

   localparam int CodeWidth  = 16;
   localparam int QtyWidth   = 16;
   localparam int PriceWidth = 24;
   localparam int OpWidth    = 3;
   localparam int StatWidth  = 2;

   localparam logic [OpWidth-1:0] OP_PUSH_FRONT = 3'd0;
   localparam logic [OpWidth-1:0] OP_PUSH_BACK  = 3'd1;
   localparam logic [OpWidth-1:0] OP_POP_FRONT  = 3'd2;
   localparam logic [OpWidth-1:0] OP_POP_BACK   = 3'd3;
   localparam logic [OpWidth-1:0] OP_SEARCH     = 3'd4;

   localparam logic [StatWidth-1:0] STAT_DONE  = 2'd0;
   localparam logic [StatWidth-1:0] STAT_FULL  = 2'd1;
   localparam logic [StatWidth-1:0] STAT_EMPTY = 2'd2;
   localparam logic [StatWidth-1:0] STAT_MISS  = 2'd3;

   typedef struct packed {
      logic [PriceWidth-1:0] price;
      logic [QtyWidth-1:0]   quantity;
      logic [CodeWidth-1:0]  code;
   } record_type;

   typedef struct packed {
      logic [StatWidth-1:0] status;
      logic                 hit;
      record_type           rec;
   } result_type;

   typedef struct packed {
      logic       valid;
      result_type data;
   } result_hs_type;

endpackage

### rtl/kdeq_store.sv
// record memory: one write port, one read port with registered data
module kdeq_store #(
   parameter int DEPTH = 16
) (
   input  logic                        clock,
   input  logic                        wr_en,
   input  logic [$clog2(DEPTH)-1:0]    wr_addr,
   input  kdeq_pkg::record_type        wr_data,
   input  logic                        rd_en,
   input  logic [$clog2(DEPTH)-1:0]    rd_addr,
   output kdeq_pkg::record_type        rd_data
);

   kdeq_pkg::record_type mem_ff [DEPTH];
   kdeq_pkg::record_type rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

### rtl/kdeq_seq.sv
// sequencer: ring pointers, shared ring adder and key comparator
module kdeq_seq #(
   parameter int DEPTH = 16
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_ready,
   input  logic [kdeq_pkg::OpWidth-1:0]        req_op,
   input  kdeq_pkg::record_type                req_rec,
   output logic                                wr_en,
   output logic [$clog2(DEPTH)-1:0]            wr_addr,
   output kdeq_pkg::record_type                wr_data,
   output logic                                rd_en,
   output logic [$clog2(DEPTH)-1:0]            rd_addr,
   input  kdeq_pkg::record_type                rd_data,
   output kdeq_pkg::result_hs_type             res,
   input  logic                                res_take
);

   localparam int IW = $clog2(DEPTH);
   localparam int CW = $clog2(DEPTH + 1);
   localparam int SW = IW + 1;

   typedef enum logic [3:0] {
      ST_IDLE   = 4'b0001,
      ST_POP    = 4'b0010,
      ST_SCAN   = 4'b0100,
      ST_RESULT = 4'b1000
   } state_type;

   state_type                         state_ff, state_in;
   logic [IW-1:0]                     head_ff, head_in;
   logic [CW-1:0]                     fill_ff, fill_in;
   logic [CW-1:0]                     idx_ff, idx_in;
   logic [IW-1:0]                     slot_ff, slot_in;
   logic [kdeq_pkg::CodeWidth-1:0]    key_ff, key_in;
   kdeq_pkg::result_type              res_ff, res_in;

   // shared ring adder
   logic [IW-1:0] add_base;
   logic [CW-1:0] add_off;
   logic [SW-1:0] add_raw;
   logic [IW-1:0] add_sum;

   logic full, empty, accept;
   logic [CW-1:0] idx_next;

   assign add_raw = SW'(add_base) + SW'(add_off);
   assign add_sum = (add_raw >= SW'(DEPTH)) ? IW'(add_raw - SW'(DEPTH)) : add_raw[IW-1:0];

   assign full     = (fill_ff == CW'(DEPTH));
   assign empty    = (fill_ff == '0);
   assign req_ready = (state_ff == ST_IDLE);
   assign accept   = req_valid && req_ready;
   assign idx_next = idx_ff + CW'(1);

   always_comb begin
      state_in = state_ff;
      head_in  = head_ff;
      fill_in  = fill_ff;
      idx_in   = idx_ff;
      slot_in  = slot_ff;
      key_in   = key_ff;
      res_in   = res_ff;
      add_base = head_ff;
      add_off  = '0;
      wr_en    = 1'b0;
      wr_addr  = add_sum;
      wr_data  = req_rec;
      rd_en    = 1'b0;
      rd_addr  = head_ff;

      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               key_in   = req_rec.code;
               res_in   = '0;
               state_in = ST_RESULT;
               unique case (req_op) inside
                  kdeq_pkg::OP_PUSH_FRONT, kdeq_pkg::OP_PUSH_BACK: begin
                     if (full) begin
                        res_in.status = kdeq_pkg::STAT_FULL;
                     end else begin
                        if (req_op == kdeq_pkg::OP_PUSH_FRONT) begin
                           add_off = CW'(DEPTH - 1);
                           head_in = add_sum;
                        end else begin
                           add_off = fill_ff;
                        end
                        wr_en   = 1'b1;
                        fill_in = fill_ff + CW'(1);
                     end
                  end
                  kdeq_pkg::OP_POP_FRONT, kdeq_pkg::OP_POP_BACK: begin
                     if (empty) begin
                        res_in.status = kdeq_pkg::STAT_EMPTY;
                     end else begin
                        rd_en = 1'b1;
                        if (req_op == kdeq_pkg::OP_POP_FRONT) begin
                           add_off = CW'(1);
                           rd_addr = head_ff;
                           head_in = add_sum;
                        end else begin
                           add_off = fill_ff - CW'(1);
                           rd_addr = add_sum;
                        end
                        fill_in  = fill_ff - CW'(1);
                        state_in = ST_POP;
                     end
                  end
                  kdeq_pkg::OP_SEARCH: begin
                     if (empty) begin
                        res_in.status   = kdeq_pkg::STAT_MISS;
                        res_in.rec.code = req_rec.code;
                     end else begin
                        rd_en    = 1'b1;
                        rd_addr  = head_ff;
                        slot_in  = head_ff;
                        idx_in   = '0;
                        state_in = ST_SCAN;
                     end
                  end
                  default: begin
                     res_in = '0;
                  end
               endcase
            end
         end
         ST_POP: begin
            res_in.status = kdeq_pkg::STAT_DONE;
            res_in.hit    = 1'b0;
            res_in.rec    = rd_data;
            state_in      = ST_RESULT;
         end
         ST_SCAN: begin
            // one stored entry compared per cycle, front first
            add_base = slot_ff;
            add_off  = CW'(1);
            if (rd_data.code == key_ff) begin
               res_in.status = kdeq_pkg::STAT_DONE;
               res_in.hit    = 1'b1;
               res_in.rec    = rd_data;
               state_in      = ST_RESULT;
            end else if (idx_next == fill_ff) begin
               res_in          = '0;
               res_in.status   = kdeq_pkg::STAT_MISS;
               res_in.rec.code = key_ff;
               state_in        = ST_RESULT;
            end else begin
               rd_en   = 1'b1;
               rd_addr = add_sum;
               slot_in = add_sum;
               idx_in  = idx_next;
            end
         end
         ST_RESULT: begin
            if (res_take) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         head_ff  <= '0;
         fill_ff  <= '0;
      end else begin
         state_ff <= state_in;
         head_ff  <= head_in;
         fill_ff  <= fill_in;
      end
   end

   always_ff @(posedge clock) begin
      idx_ff  <= idx_in;
      slot_ff <= slot_in;
      key_ff  <= key_in;
      res_ff  <= res_in;
   end

   assign res.valid = (state_ff == ST_RESULT);
   assign res.data  = res_ff;

endmodule

### rtl/keyed_record_deque_with_search.sv
// keyed record deque: stream ports, output register, sequencer and record memory
// push, unused op, full push, empty pop or empty search: result registered in the sequencer,
// then in the rsp register; pop adds a registered memory read; search ends at the first match
// from the front or misses after all held records; one record compared per cycle on the
// single memory read port. req_tready returns once the result moves to the rsp register.
// reset clears head, fill count and control; memory contents are not cleared.
module keyed_record_deque_with_search #(
   parameter int DEPTH = 16
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [55:0] req_tdata,   // key_code[15:0], quantity[31:16], price[55:32]
   input  logic [2:0]  req_tuser,   // op[2:0]
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [55:0] rsp_tdata,   // out_code[15:0], out_quantity[31:16], out_price[55:32]
   output logic [2:0]  rsp_tuser    // status[1:0], hit[2]
);

   localparam int IW = $clog2(DEPTH);

   kdeq_pkg::record_type     req_rec;
   kdeq_pkg::record_type     wr_data;
   kdeq_pkg::record_type     rd_data;
   kdeq_pkg::result_hs_type  res;
   kdeq_pkg::result_type     out_ff;
   logic                     out_valid_ff, out_valid_in;
   logic                     res_take;
   logic                     wr_en, rd_en;
   logic [IW-1:0]            wr_addr, rd_addr;

   assign req_rec.code     = req_tdata[15:0];
   assign req_rec.quantity = req_tdata[31:16];
   assign req_rec.price    = req_tdata[55:32];

   // result moves on when the output register is empty or draining
   assign res_take     = res.valid && (!out_valid_ff || rsp_tready);
   assign out_valid_in = res_take || (out_valid_ff && !rsp_tready);

   kdeq_seq #(.DEPTH(DEPTH)) u_seq (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_tvalid),
      .req_ready (req_tready),
      .req_op    (req_tuser),
      .req_rec   (req_rec),
      .wr_en     (wr_en),
      .wr_addr   (wr_addr),
      .wr_data   (wr_data),
      .rd_en     (rd_en),
      .rd_addr   (rd_addr),
      .rd_data   (rd_data),
      .res       (res),
      .res_take  (res_take)
   );

   kdeq_store #(.DEPTH(DEPTH)) u_store (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else begin
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (res_take) begin
         out_ff <= res.data;
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = {out_ff.rec.price, out_ff.rec.quantity, out_ff.rec.code};
   assign rsp_tuser  = {out_ff.hit, out_ff.status};

endmodule

### tb/tb_top.sv
// stream testbench for the keyed record deque: driver, monitor and in-line predictor
module tb_top;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int DEPTH = 16;
   localparam int IW = $clog2(DEPTH);

   typedef struct packed {
      logic [kdeq_pkg::OpWidth-1:0] op;
      kdeq_pkg::record_type         rec;
   } deque_cmd_type;

   logic        clock;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [55:0] req_tdata = '0;   // key_code[15:0], quantity[31:16], price[55:32]
   logic [2:0]  req_tuser = '0;   // op[2:0]
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [55:0] rsp_tdata;        // out_code[15:0], out_quantity[31:16], out_price[55:32]
   logic [2:0]  rsp_tuser;        // status[1:0], hit[2]

   keyed_record_deque_with_search #(.DEPTH(DEPTH)) u_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

   // commands waiting for the driver, and results still owed by the block
   deque_cmd_type        cmd_queue[$];
   kdeq_pkg::result_type owed_results[$];

   // shadow copy of the deque
   kdeq_pkg::record_type slots[DEPTH];
   int         front = 0;
   int         held = 0;
   int         deepest = 0;

   int total_cmds = 0;
   int accepted = 0;
   int words_seen = 0;
   int errors = 0;
   int n_hit = 0;
   int n_miss = 0;
   int n_drop = 0;
   int n_empty = 0;
   int n_ignored = 0;

   logic [kdeq_pkg::CodeWidth-1:0] code_pool[8];

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   initial begin
      #2_000_000;
      $display("%0t: timeout, %0d of %0d words accepted, %0d results owed",
               $time, accepted, total_cmds, owed_results.size());
      $display("FAILURE");
      $finish;
   end

   function automatic kdeq_pkg::result_type deque_apply(input deque_cmd_type c);
      kdeq_pkg::result_type r;
      int         slot;
      logic       found;
      r = '0;
      found = 1'b0;
      case (c.op) inside
         kdeq_pkg::OP_PUSH_FRONT, kdeq_pkg::OP_PUSH_BACK: begin
            if (held == DEPTH) begin
               r.status = kdeq_pkg::STAT_FULL;
               n_drop++;
            end else begin
               if (c.op == kdeq_pkg::OP_PUSH_FRONT) begin
                  front = (front + DEPTH - 1) % DEPTH;
                  slot = front;
               end else begin
                  slot = (front + held) % DEPTH;
               end
               slots[IW'(slot)] = c.rec;
               held++;
               if (held > deepest) deepest = held;
               r.status = kdeq_pkg::STAT_DONE;
            end
         end
         kdeq_pkg::OP_POP_FRONT, kdeq_pkg::OP_POP_BACK: begin
            if (held == 0) begin
               r.status = kdeq_pkg::STAT_EMPTY;
               n_empty++;
            end else begin
               if (c.op == kdeq_pkg::OP_POP_FRONT) begin
                  slot = front;
                  front = (front + 1) % DEPTH;
               end else begin
                  slot = (front + held - 1) % DEPTH;
               end
               held--;
               r.status = kdeq_pkg::STAT_DONE;
               r.rec = slots[IW'(slot)];
            end
         end
         kdeq_pkg::OP_SEARCH: begin
            // nearest match to the front wins
            for (int i = 0; i < held; i++) begin
               slot = (front + i) % DEPTH;
               if (!found && slots[IW'(slot)].code == c.rec.code) begin
                  found = 1'b1;
                  r.rec = slots[IW'(slot)];
               end
            end
            if (found) begin
               r.status = kdeq_pkg::STAT_DONE;
               r.hit = 1'b1;
               n_hit++;
            end else begin
               r.status = kdeq_pkg::STAT_MISS;
               r.rec.code = c.rec.code;
               n_miss++;
            end
         end
         default: begin
            n_ignored++;
         end
      endcase
      return r;
   endfunction

   task automatic add_cmd(input logic [kdeq_pkg::OpWidth-1:0] op,
                          input logic [kdeq_pkg::CodeWidth-1:0] code,
                          input logic [kdeq_pkg::QtyWidth-1:0] qty,
                          input logic [kdeq_pkg::PriceWidth-1:0] price);
      deque_cmd_type c;
      c.op = op;
      c.rec.code = code;
      c.rec.quantity = qty;
      c.rec.price = price;
      cmd_queue.push_back(c);
      total_cmds++;
   endtask

   function automatic logic [kdeq_pkg::CodeWidth-1:0] pick_code();
      if ($urandom_range(0, 3) != 0) return code_pool[3'($urandom_range(0, 7))];
      return 16'($urandom);
   endfunction

   // driver: one word in flight on req, random gaps between words
   int            idle_left = 0;
   int            sent = 0;
   deque_cmd_type on_bus;

   always @(posedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
         idle_left <= 0;
      end else begin
         if (req_tvalid && req_tready) begin
            owed_results.push_back(deque_apply(on_bus));
            accepted++;
         end
         if (!req_tvalid || req_tready) begin
            if (idle_left > 0) begin
               idle_left <= idle_left - 1;
               req_tvalid <= 1'b0;
            end else if (cmd_queue.size() > 0) begin
               on_bus = cmd_queue.pop_front();
               req_tdata <= on_bus.rec;
               req_tuser <= on_bus.op;
               req_tvalid <= 1'b1;
               sent++;
               // every third window of 40 words runs back to back
               idle_left <= ((sent / 40) % 3 == 2) ? 0 : $urandom_range(0, 17);
            end else begin
               req_tvalid <= 1'b0;
            end
         end
      end
   end

   task automatic check_field(input string name, input logic [23:0] want,
                              input logic [23:0] got);
      if (got !== want) begin
         $display("%0t: word %0d %s mismatch, expected %0h, actual %0h",
                  $time, words_seen, name, want, got);
         errors++;
      end
   endtask

   // monitor: random stalls, plus one long hold-off so the block backs up
   int stall_left = 0;
   int hold_left = 0;

   always @(posedge clock) begin
      int                   s;
      int                   h;
      kdeq_pkg::result_type want;
      s = stall_left;
      h = hold_left;
      if (reset) begin
         s = 0;
         h = 0;
      end else if (rsp_tvalid && rsp_tready) begin
         if (owed_results.size() == 0) begin
            $display("%0t: unexpected word, expected none, actual tuser %0h tdata %0h",
                     $time, rsp_tuser, rsp_tdata);
            errors++;
         end else begin
            want = owed_results.pop_front();
            check_field("status", 24'(want.status), 24'(rsp_tuser[1:0]));
            check_field("hit", 24'(want.hit), 24'(rsp_tuser[2]));
            check_field("out_code", 24'(want.rec.code), 24'(rsp_tdata[15:0]));
            check_field("out_quantity", 24'(want.rec.quantity), 24'(rsp_tdata[31:16]));
            check_field("out_price", want.rec.price, rsp_tdata[55:32]);
         end
         words_seen++;
         s = ((words_seen / 50) % 4 == 1) ? 0 : $urandom_range(0, 17);
         if (words_seen == 150) h = 400;
      end else if (h > 0) begin
         h--;
      end else if (s > 0) begin
         s--;
      end
      stall_left <= s;
      hold_left <= h;
      rsp_tready <= !reset && s == 0 && h == 0;
   end

   initial begin
      int phase_kind;
      int phase_len;
      int rnd_count;
      int pct;
      logic [kdeq_pkg::OpWidth-1:0] op;

      code_pool[0] = '0;
      code_pool[1] = '1;
      for (int i = 2; i < 8; i++) code_pool[3'(i)] = 16'($urandom);

      // empty store, unused op codes, field extremes, duplicate codes
      add_cmd(kdeq_pkg::OP_POP_FRONT, 16'h1111, 16'h2222, 24'h333333);
      add_cmd(kdeq_pkg::OP_POP_BACK, '1, '1, '1);
      add_cmd(kdeq_pkg::OP_SEARCH, 16'h0000, '0, '0);
      add_cmd(3'd5, '1, '1, '1);
      add_cmd(3'd6, 16'h1234, 16'h5678, 24'h9abcde);
      add_cmd(3'd7, '0, '0, '0);
      add_cmd(kdeq_pkg::OP_PUSH_FRONT, '0, '0, '0);
      add_cmd(kdeq_pkg::OP_PUSH_BACK, '1, '1, '1);
      add_cmd(kdeq_pkg::OP_PUSH_FRONT, '1, 16'h0001, 24'h000001);
      add_cmd(kdeq_pkg::OP_PUSH_BACK, 16'h8000, 16'h8000, 24'h800000);
      add_cmd(kdeq_pkg::OP_SEARCH, '1, '0, '0);
      add_cmd(kdeq_pkg::OP_SEARCH, 16'h0000, '1, '1);
      add_cmd(kdeq_pkg::OP_SEARCH, 16'h8000, '0, '0);
      add_cmd(kdeq_pkg::OP_SEARCH, 16'h7fff, 16'h1234, 24'h123456);
      add_cmd(kdeq_pkg::OP_POP_BACK, '0, '0, '0);
      add_cmd(kdeq_pkg::OP_POP_FRONT, '0, '0, '0);
      add_cmd(kdeq_pkg::OP_SEARCH, '1, '0, '0);
      add_cmd(kdeq_pkg::OP_POP_BACK, '0, '0, '0);
      add_cmd(kdeq_pkg::OP_POP_FRONT, '0, '0, '0);
      add_cmd(kdeq_pkg::OP_POP_FRONT, '0, '0, '0);

      // random phases: fill, drain, search-heavy and free mix; first one fills
      rnd_count = 0;
      phase_kind = 0;
      while (rnd_count < 500) begin
         phase_len = (rnd_count == 0) ? 40 : $urandom_range(10, 40);
         for (int k = 0; k < phase_len; k++) begin
            pct = $urandom_range(0, 99);
            case (phase_kind)
               0: op = (pct < 85) ? 3'($urandom_range(0, 1)) : 3'($urandom_range(2, 4));
               1: op = (pct < 80) ? 3'($urandom_range(2, 3)) : 3'($urandom_range(0, 1));
               2: op = (pct < 60) ? kdeq_pkg::OP_SEARCH : 3'($urandom_range(0, 3));
               default: op = (pct < 10) ? 3'($urandom_range(5, 7))
                                        : 3'($urandom_range(0, 4));
            endcase
            if ($urandom_range(0, 9) == 0)
               add_cmd(op, pick_code(), $urandom_range(0, 1) ? '1 : '0,
                       $urandom_range(0, 1) ? '1 : '0);
            else
               add_cmd(op, pick_code(), 16'($urandom), 24'($urandom));
            rnd_count++;
         end
         phase_kind = $urandom_range(0, 3);
      end

      repeat (9) @(posedge clock);
      reset <= 1'b0;

      while (accepted < total_cmds) @(posedge clock);
      while (owed_results.size() > 0) @(posedge clock);
      repeat (DEPTH + 10) @(posedge clock);

      $display("run covered %0d words: %0d search hits, %0d misses, %0d full pushes dropped",
               words_seen, n_hit, n_miss, n_drop);
      $display("%0d empty pops, %0d unused op codes, deepest fill %0d of %0d",
               n_empty, n_ignored, deepest, DEPTH);
      if (errors == 0) begin
         $display("SUCCESS");
      end else begin
         $display("FAILURE");
      end
      $finish;
   end

endmodule

### sim.f
rtl/kdeq_pkg.sv
rtl/kdeq_store.sv
rtl/kdeq_seq.sv
rtl/keyed_record_deque_with_search.sv
tb/tb_top.sv
